>>> rtl/tals_pkg.sv
// ----------------------------------------------------------------------------
// tals_pkg: shared types and constants
// Operation codes, register indexes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package tals_pkg;

    localparam int FEED_W = 16;
    localparam int IVL_W  = 26;
    localparam int PROD_W = 32;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    localparam logic [1:0] REG_STEPS_Z   = 2'd0;
    localparam logic [1:0] REG_RAPID     = 2'd1;
    localparam logic [1:0] REG_MAX_FEED  = 2'd2;
    localparam logic [1:0] REG_DEF_IVL   = 2'd3;

    localparam logic [PROD_W-1:0] US_PER_MIN   = 32'd60000000;
    localparam logic [IVL_W-1:0]  MIN_INTERVAL = 26'd200;

    typedef struct packed {
        logic prep;      // latch item, compute deltas and product
        logic div_start; // start interval division
        logic commit;    // start move with computed interval
        logic set_pos;   // write position from item
        logic tick;      // apply one tick
        logic emit;      // capture result word
    } tals_cmd_t;

    typedef struct packed {
        logic moving;
        logic zero_len;
        logic div_done;
    } tals_sts_t;

endpackage

>>> rtl/tals_if.sv
// ----------------------------------------------------------------------------
// tals_if: valid/ready channel
// Generic word channel with source and sink views.
// ----------------------------------------------------------------------------
interface tals_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tals_ctrl.sv
// ----------------------------------------------------------------------------
// tals_ctrl: sequencer
// Accepts one word, drives datapath commands, presents the result word.
// ----------------------------------------------------------------------------
module tals_ctrl
    import tals_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] op,
    output logic      out_valid,
    input  logic      out_ready,
    input  tals_sts_t sts,
    output tals_cmd_t cmd
);
    typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_WAIT, S_EMIT} state_t;

    state_t     state_reg;
    logic [1:0] op_reg;
    logic       out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.prep      = in_valid && in_ready;
        cmd.div_start = (state_reg == S_PREP) && (op_reg == OP_LOAD) && !sts.moving
                        && !sts.zero_len;
        cmd.commit    = (state_reg == S_WAIT) && sts.div_done;
        cmd.set_pos   = (state_reg == S_PREP) && (op_reg == OP_SET) && !sts.moving;
        cmd.tick      = (state_reg == S_PREP) && (op_reg == OP_TICK) && sts.moving;
        cmd.emit      = (state_reg == S_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg    <= op;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (cmd.div_start)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_EMIT;
                end
                S_DIV:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (sts.div_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |=> out_valid_reg)
        else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("accept while working");
    a_commit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (state_reg == S_WAIT))
        else $error("commit out of order");
`endif
endmodule

>>> rtl/tals_dp.sv
// ----------------------------------------------------------------------------
// tals_dp: step datapath
// Position, Bresenham error terms, interval divider and tick countdown.
// ----------------------------------------------------------------------------
module tals_dp
    import tals_pkg::*;
#(
    parameter int POS_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tals_cmd_t         cmd,
    output tals_sts_t         sts,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              cfg_we,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic [2:0]        in_keep,
    input  logic [15:0]       in_feed,
    input  logic              in_rapid,
    output logic [2:0]        res_step,
    output logic [2:0]        res_dir,
    output logic              res_busy,
    output logic              res_done,
    output logic signed [31:0] res_px,
    output logic signed [31:0] res_py,
    output logic signed [31:0] res_pz
);
    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [FEED_W-1:0] steps_z_reg, rapid_reg, max_feed_reg;
    logic [IVL_W-1:0]  def_ivl_reg;

    logic signed [POS_BITS-1:0] pos_reg [3];
    logic signed [POS_BITS-1:0] tgt_reg [3];
    logic signed [POS_BITS-1:0] item_pos_reg [3];
    logic [POS_BITS-1:0] adelta_reg [3];
    logic [POS_BITS-1:0] err_reg [3];
    logic [POS_BITS-1:0] longest_reg, steps_done_reg;
    logic [IVL_W-1:0]    ivl_reg, cnt_reg;
    logic [2:0]          dir_reg;
    logic                moving_reg;

    logic signed [POS_BITS:0] d_reg [3];
    logic [PROD_W-1:0]   prod_reg;

    logic [PROD_W-1:0]   quo_reg, rem_reg;
    logic [CNT_W-1:0]    bit_cnt_reg;
    logic                div_busy_reg, div_done_reg;

    logic [2:0]          step_reg;
    logic                done_reg;

    logic signed [POS_BITS-1:0] in_t [3];
    logic signed [POS_BITS-1:0] t_sel [3];
    logic signed [POS_BITS:0]   d_c [3];
    logic [POS_BITS-1:0]        a_c [3];
    logic [POS_BITS-1:0]        longest_c;
    logic [FEED_W-1:0]          feed_c;
    logic [POS_BITS:0]          e_c [3];
    logic [POS_BITS-1:0]        e_new [3];
    logic [2:0]                 step_c;
    logic [PROD_W:0]            rem_sh;
    logic [IVL_W-1:0]           ivl_c;
    logic [POS_BITS-1:0]        sd_inc;

    assign in_t[0] = in_x[POS_BITS-1:0];
    assign in_t[1] = in_y[POS_BITS-1:0];
    assign in_t[2] = in_z[POS_BITS-1:0];

    always_comb
    begin
        longest_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            t_sel[i] = in_keep[i] ? pos_reg[i] : in_t[i];
            d_c[i]   = {t_sel[i][POS_BITS-1], t_sel[i]} - {pos_reg[i][POS_BITS-1], pos_reg[i]};
            a_c[i]   = d_c[i][POS_BITS] ? POS_BITS'(-d_c[i]) : d_c[i][POS_BITS-1:0];
            if (a_c[i] > longest_c)
                longest_c = a_c[i];
        end
        feed_c = in_rapid ? rapid_reg : in_feed;
        if (feed_c > max_feed_reg)
            feed_c = max_feed_reg;
        step_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            e_c[i] = {1'b0, err_reg[i]} + {1'b0, adelta_reg[i]};
            if (e_c[i] >= {1'b0, longest_reg})
            begin
                e_new[i]  = POS_BITS'(e_c[i] - {1'b0, longest_reg});
                step_c[i] = 1'b1;
            end
            else
                e_new[i] = e_c[i][POS_BITS-1:0];
        end
        sd_inc = steps_done_reg + 1'b1;
        rem_sh = {rem_reg, US_PER_MIN[PROD_W-1 - bit_cnt_reg[CNT_W-2:0]]};
        if (prod_reg == '0)
            ivl_c = def_ivl_reg;
        else if (quo_reg < PROD_W'(MIN_INTERVAL))
            ivl_c = MIN_INTERVAL;
        else
            ivl_c = quo_reg[IVL_W-1:0];
    end

    assign sts.moving   = moving_reg;
    assign sts.zero_len = (longest_reg == '0);
    assign sts.div_done = div_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_z_reg  <= 16'd3930;
            rapid_reg    <= 16'd1000;
            max_feed_reg <= 16'd1000;
            def_ivl_reg  <= 26'd1000;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]      <= '0;
                tgt_reg[i]      <= '0;
                item_pos_reg[i] <= '0;
                adelta_reg[i]   <= '0;
                err_reg[i]      <= '0;
                d_reg[i]        <= '0;
            end
            longest_reg    <= '0;
            steps_done_reg <= '0;
            ivl_reg        <= '0;
            cnt_reg        <= '0;
            dir_reg        <= '0;
            moving_reg     <= 1'b0;
            div_busy_reg   <= 1'b0;
            div_done_reg   <= 1'b0;
            bit_cnt_reg    <= '0;
            step_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEPS_Z:  steps_z_reg  <= cfg_data[FEED_W-1:0];
                    REG_RAPID:    rapid_reg    <= cfg_data[FEED_W-1:0];
                    REG_MAX_FEED: max_feed_reg <= cfg_data[FEED_W-1:0];
                    REG_DEF_IVL:  def_ivl_reg  <= cfg_data[IVL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.prep)
            begin
                step_reg <= '0;
                done_reg <= 1'b0;
                div_done_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                    item_pos_reg[i] <= in_t[i];
                if (!moving_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        tgt_reg[i]    <= t_sel[i];
                        d_reg[i]      <= d_c[i];
                        adelta_reg[i] <= a_c[i];
                    end
                    longest_reg <= longest_c;
                    prod_reg    <= PROD_W'(feed_c) * PROD_W'(steps_z_reg);
                end
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= (prod_reg != '0);
                div_done_reg <= (prod_reg == '0);
                bit_cnt_reg  <= '0;
                rem_reg      <= '0;
                quo_reg      <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    err_reg[i] <= longest_reg >> 1;
                    if (d_reg[i] != '0)
                        dir_reg[i] <= (i == 2) ? d_reg[i][POS_BITS] : !d_reg[i][POS_BITS];
                end
            end
            else if (div_busy_reg)
            begin
                if (rem_sh >= {1'b0, prod_reg})
                begin
                    rem_reg <= PROD_W'(rem_sh - {1'b0, prod_reg});
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[PROD_W-1:0];
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
                end
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                div_done_reg   <= 1'b0;
                ivl_reg        <= ivl_c;
                cnt_reg        <= ivl_c;
                steps_done_reg <= '0;
                moving_reg     <= 1'b1;
            end
            if (cmd.set_pos)
            begin
                for (int i = 0; i < 3; i++)
                    pos_reg[i] <= item_pos_reg[i];
            end
            if (cmd.tick)
            begin
                if (cnt_reg > IVL_W'(1))
                    cnt_reg <= cnt_reg - 1'b1;
                else
                begin
                    cnt_reg <= ivl_reg;
                    for (int i = 0; i < 3; i++)
                        err_reg[i] <= e_new[i];
                    step_reg       <= step_c;
                    steps_done_reg <= sd_inc;
                    if (sd_inc >= longest_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                            pos_reg[i] <= tgt_reg[i];
                        moving_reg <= 1'b0;
                        done_reg   <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_step <= step_reg;
            res_dir  <= dir_reg;
            res_busy <= moving_reg;
            res_done <= done_reg;
            res_px   <= 32'(pos_reg[0]);
            res_py   <= 32'(pos_reg[1]);
            res_pz   <= 32'(pos_reg[2]);
        end
    end

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick && done_reg) |-> !moving_reg)
        else $error("done while moving");
    a_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_busy_reg && div_done_reg))
        else $error("divider state clash");
    a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(moving_reg) |-> (longest_reg != '0))
        else $error("empty move started");
`endif
endmodule

>>> rtl/three_axis_line_step_generator.sv
// ----------------------------------------------------------------------------
// three_axis_line_step_generator: 3-axis line step generator
//
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    op, targets, keep_mask, feed_rate, rapid
//  out_ch   out  valid/ready    steps, dirs, busy_res, move_done, positions
//  cfg_ch   in   valid/ready    index, data
//
// Tick, set, spare and zero-length load words, and loads during a move, go
// from accept through prep and emit back to idle; a load that starts a move
// also waits on the 32-step restoring divider, skipped at zero feed product.
// Reset is asynchronous and leaves the block idle with registers at defaults.
// A result waits in the output register; the next word is taken once the
// pending result is taken or in the same cycle.
// ----------------------------------------------------------------------------
module three_axis_line_step_generator
    import tals_pkg::*;
#(
    parameter int POS_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    tals_if.sink   in_ch,
    tals_if.source out_ch,
    tals_if.sink   cfg_ch
);
    tals_cmd_t cmd;
    tals_sts_t sts;

    logic [2:0]  r_step, r_dir;
    logic        r_busy, r_done;
    logic signed [31:0] r_px, r_py, r_pz;

    assign cfg_ch.ready = 1'b1;

    tals_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .op        (in_ch.data[1:0]),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tals_dp #(.POS_BITS(POS_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_index (cfg_ch.data[33:32]),
        .cfg_data  (cfg_ch.data[31:0]),
        .cfg_we    (cfg_ch.valid),
        .in_x      (in_ch.data[33:2]),
        .in_y      (in_ch.data[65:34]),
        .in_z      (in_ch.data[97:66]),
        .in_keep   (in_ch.data[100:98]),
        .in_feed   (in_ch.data[116:101]),
        .in_rapid  (in_ch.data[117]),
        .res_step  (r_step),
        .res_dir   (r_dir),
        .res_busy  (r_busy),
        .res_done  (r_done),
        .res_px    (r_px),
        .res_py    (r_py),
        .res_pz    (r_pz)
    );

    assign out_ch.data = {r_pz, r_py, r_px, r_done, r_busy, r_dir, r_step};
endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: three-axis line step generator testbench
// Drives load, tick, set and spare words with random gaps and sink stalls. A local
// model of the stepper predicts every result word, which is compared field
// by field as it leaves the block. Register settings cover the extremes.
// ----------------------------------------------------------------------------
module tb;
    import tals_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 3000000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic        rapid;
        logic [15:0] feed;
        logic [2:0]  keep;
        logic [31:0] tz;
        logic [31:0] ty;
        logic [31:0] tx;
        logic [1:0]  op;
    } move_item_t;

    typedef struct packed {
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic        done;
        logic        busy;
        logic        dir_z;
        logic        dir_y;
        logic        dir_x;
        logic        step_z;
        logic        step_y;
        logic        step_x;
    } step_word_t;

    logic clk;
    logic rst_n;

    tals_if #(.W($bits(move_item_t))) in_ch ();
    tals_if #(.W($bits(step_word_t))) out_ch ();
    tals_if #(.W(34)) cfg_ch ();

    three_axis_line_step_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // model state
    logic [15:0] r_steps_z;
    logic [15:0] r_rapid;
    logic [15:0] r_max_feed;
    logic [25:0] r_def_ivl;
    longint      cur_pos [3];
    longint      tgt_pos [3];
    longint      abs_d [3];
    longint      err_acc [3];
    longint      longest;
    longint      steps_taken;
    logic [25:0] ivl;
    logic [25:0] cdown;
    logic [2:0]  dir_pins;
    bit          moving;

    step_word_t  pending_words [$];
    int          mismatches;
    int          cycles;
    bit          calm;
    int          stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [25:0] step_interval(logic [15:0] feed);
        longint unsigned prod;
        longint unsigned q;
        prod = longint'(feed) * longint'(r_steps_z);
        if (prod == 0)
            return r_def_ivl;
        q = 64'd60000000 / prod;
        if (q < 200)
            q = 200;
        return q[25:0];
    endfunction

    function automatic step_word_t advance_stepper(move_item_t it);
        step_word_t  w;
        logic [2:0]  stp;
        logic        fin;
        logic [15:0] feed;
        longint      t [3];
        longint      d [3];
        longint      lng;
        longint      e;
        stp = 3'b000;
        fin = 1'b0;
        if (it.op == OP_LOAD && !moving)
        begin
            feed = it.rapid ? r_rapid : it.feed;
            if (feed > r_max_feed)
                feed = r_max_feed;
            t[0] = it.keep[0] ? cur_pos[0] : longint'($signed(it.tx));
            t[1] = it.keep[1] ? cur_pos[1] : longint'($signed(it.ty));
            t[2] = it.keep[2] ? cur_pos[2] : longint'($signed(it.tz));
            lng = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = t[i] - cur_pos[i];
                if ((d[i] < 0 ? -d[i] : d[i]) > lng)
                    lng = d[i] < 0 ? -d[i] : d[i];
            end
            if (lng != 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tgt_pos[i] = t[i];
                    abs_d[i] = d[i] < 0 ? -d[i] : d[i];
                    err_acc[i] = lng / 2;
                    if (d[i] != 0)
                        dir_pins[i] = (i == 2) ? (d[i] < 0) : (d[i] >= 0);
                end
                longest = lng;
                steps_taken = 0;
                ivl = step_interval(feed);
                cdown = ivl;
                moving = 1'b1;
            end
        end
        else if (it.op == OP_TICK && moving)
        begin
            if (cdown > 1)
                cdown = cdown - 1;
            else
            begin
                cdown = ivl;
                for (int i = 0; i < 3; i++)
                begin
                    e = err_acc[i] + abs_d[i];
                    if (e >= longest)
                    begin
                        e = e - longest;
                        stp[i] = 1'b1;
                    end
                    err_acc[i] = e;
                end
                steps_taken++;
                if (steps_taken >= longest)
                begin
                    for (int i = 0; i < 3; i++)
                        cur_pos[i] = tgt_pos[i];
                    moving = 1'b0;
                    fin = 1'b1;
                end
            end
        end
        else if (it.op == OP_SET && !moving)
        begin
            cur_pos[0] = longint'($signed(it.tx));
            cur_pos[1] = longint'($signed(it.ty));
            cur_pos[2] = longint'($signed(it.tz));
        end
        w.step_x = stp[0];
        w.step_y = stp[1];
        w.step_z = stp[2];
        w.dir_x = dir_pins[0];
        w.dir_y = dir_pins[1];
        w.dir_z = dir_pins[2];
        w.busy = moving;
        w.done = fin;
        w.pos_x = cur_pos[0][31:0];
        w.pos_y = cur_pos[1][31:0];
        w.pos_z = cur_pos[2][31:0];
        return w;
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_item(move_item_t it);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge clk); while (!in_ch.ready);
        pending_words.push_back(advance_stepper(it));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold input until every result is out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [25:0] value);
        drain();
        repeat (50) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= {idx, 6'd0, value};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_STEPS_Z:  r_steps_z = value[15:0];
            REG_RAPID:    r_rapid = value[15:0];
            REG_MAX_FEED: r_max_feed = value[15:0];
            default:      r_def_ivl = value;
        endcase
    endtask

    function automatic move_item_t mk_item(logic [1:0] op, longint x, longint y, longint z,
                                           logic [2:0] keep, logic [15:0] feed, logic rapid);
        move_item_t it;
        it.op = op;
        it.tx = x[31:0];
        it.ty = y[31:0];
        it.tz = z[31:0];
        it.keep = keep;
        it.feed = feed;
        it.rapid = rapid;
        return it;
    endfunction

    function automatic longint near_target(longint p, int maxd);
        longint d;
        longint t;
        d = longint'($urandom_range(0, 2 * maxd)) - maxd;
        t = p + d;
        if (t > 64'sd2147483647 || t < -64'sd2147483648)
            t = p - d;
        return t;
    endfunction

    function automatic move_item_t noise_item();
        return mk_item($urandom_range(0, 3), $signed($urandom), $signed($urandom),
                       $signed($urandom), $urandom_range(0, 7), $urandom_range(0, 65535),
                       $urandom_range(0, 1));
    endfunction

    task automatic tick_until_done(int noise_pct);
        while (moving)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(noise_item());
            else
                send_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0));
        end
    endtask

    task automatic random_moves(int n_moves, int maxd, int noise_pct);
        longint     p;
        move_item_t it;
        for (int m = 0; m < n_moves; m++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                p = $urandom_range(0, 2) == 0 ? 64'sd2147483647 - $urandom_range(0, 40) :
                    $urandom_range(0, 1) ? -64'sd2147483648 + $urandom_range(0, 40) :
                    longint'($signed($urandom));
                send_item(mk_item(OP_SET, p, $signed($urandom),
                                  longint'($urandom_range(0, 200)) - 100, 0, 0, 0));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // keep an idle load from starting a long move
                it = noise_item();
                if (it.op == OP_LOAD)
                    it.keep = 3'b111;
                send_item(it);
            end
            if ($urandom_range(0, 19) == 0)
                drain();
            send_item(mk_item(OP_LOAD, near_target(cur_pos[0], maxd),
                              near_target(cur_pos[1], maxd), near_target(cur_pos[2], maxd),
                              $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0,
                              $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(0, 65535),
                              $urandom_range(0, 1)));
            tick_until_done(noise_pct);
        end
    endtask

    task automatic test_directed();
        write_reg(REG_DEF_IVL, 26'd2);
        send_item(mk_item(OP_SPARE, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(OP_SET, 64'sd2147483647, -64'sd2147483648, 0, 0, 0, 0));
        send_item(mk_item(OP_LOAD, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                          3'b111, 16'hFFFF, 1'b1));
        send_item(mk_item(OP_LOAD, 64'sd2147483644, -64'sd2147483646, 5, 3'b000, 0, 0));
        send_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(OP_LOAD, 1, 1, 1, 0, 0, 0));
        send_item(mk_item(OP_SET, 7, 7, 7, 0, 0, 0));
        send_item(mk_item(OP_SPARE, -1, -1, -1, 3'b111, 16'hFFFF, 1'b1));
        tick_until_done(0);
        send_item(mk_item(OP_LOAD, 0, 0, -3, 3'b011, 16'd0, 1'b0));
        tick_until_done(0);
        send_item(mk_item(OP_LOAD, 0, 0, 2, 3'b011, 16'd0, 1'b0));
        tick_until_done(0);
        send_item(mk_item(OP_SET, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_register_extremes();
        write_reg(REG_STEPS_Z, 16'hFFFF);
        write_reg(REG_RAPID, 16'hFFFF);
        write_reg(REG_MAX_FEED, 16'hFFFF);
        send_item(mk_item(OP_LOAD, cur_pos[0] + 1, cur_pos[1], cur_pos[2], 0, 0, 1'b1));
        tick_until_done(0);
        write_reg(REG_STEPS_Z, 16'd3);
        send_item(mk_item(OP_LOAD, cur_pos[0], cur_pos[1] - 1, cur_pos[2], 0, 16'hFFFF, 1'b0));
        tick_until_done(3);
        write_reg(REG_DEF_IVL, 26'h3FFFFFF);
        write_reg(REG_RAPID, 16'd0);
        send_item(mk_item(OP_LOAD, 9, 9, 9, 3'b111, 0, 1'b1));
        write_reg(REG_DEF_IVL, 26'd0);
        write_reg(REG_MAX_FEED, 16'd0);
        random_moves(6, 5, 0);
    endtask

    task automatic test_fast_moves();
        write_reg(REG_MAX_FEED, 16'd0);
        write_reg(REG_DEF_IVL, 26'd1);
        calm = 1'b1;
        random_moves(15, 12, 10);
        calm = 1'b0;
        random_moves(20, 12, 10);
        write_reg(REG_DEF_IVL, 26'd3);
        random_moves(12, 8, 15);
        write_reg(REG_STEPS_Z, 16'd3930);
        write_reg(REG_MAX_FEED, 16'd1000);
        write_reg(REG_DEF_IVL, 26'd2);
        random_moves(1, 1, 5);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        r_steps_z = 16'd3930;
        r_rapid = 16'd1000;
        r_max_feed = 16'd1000;
        r_def_ivl = 26'd1000;
        for (int i = 0; i < 3; i++)
        begin
            cur_pos[i] = 0;
            tgt_pos[i] = 0;
            abs_d[i] = 0;
            err_acc[i] = 0;
        end
        longest = 0;
        steps_taken = 0;
        ivl = '0;
        cdown = '0;
        dir_pins = '0;
        moving = 1'b0;
        mismatches = 0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_fast_moves();
        drain();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        step_word_t act;
        step_word_t exp_w;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                act = out_ch.data;
                if (pending_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    exp_w = pending_words.pop_front();
                    if (act !== exp_w)
                        mismatches++;
                    if (act.step_x !== exp_w.step_x)
                        $error("step_x expected %0d got %0d", exp_w.step_x, act.step_x);
                    if (act.step_y !== exp_w.step_y)
                        $error("step_y expected %0d got %0d", exp_w.step_y, act.step_y);
                    if (act.step_z !== exp_w.step_z)
                        $error("step_z expected %0d got %0d", exp_w.step_z, act.step_z);
                    if (act.dir_x !== exp_w.dir_x)
                        $error("dir_x expected %0d got %0d", exp_w.dir_x, act.dir_x);
                    if (act.dir_y !== exp_w.dir_y)
                        $error("dir_y expected %0d got %0d", exp_w.dir_y, act.dir_y);
                    if (act.dir_z !== exp_w.dir_z)
                        $error("dir_z expected %0d got %0d", exp_w.dir_z, act.dir_z);
                    if (act.busy !== exp_w.busy)
                        $error("busy_res expected %0d got %0d", exp_w.busy, act.busy);
                    if (act.done !== exp_w.done)
                        $error("move_done expected %0d got %0d", exp_w.done, act.done);
                    if (act.pos_x !== exp_w.pos_x)
                        $error("pos_x expected %0d got %0d",
                               $signed(exp_w.pos_x), $signed(act.pos_x));
                    if (act.pos_y !== exp_w.pos_y)
                        $error("pos_y expected %0d got %0d",
                               $signed(exp_w.pos_y), $signed(act.pos_y));
                    if (act.pos_z !== exp_w.pos_z)
                        $error("pos_z expected %0d got %0d",
                               $signed(exp_w.pos_z), $signed(act.pos_z));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 39) == 0)
            begin
                stall_left <= $urandom_range(5, 40);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= calm || $urandom_range(0, 9) < 7;
        end
    end

    initial
    begin
        cycles = 0;
        stall_left = 0;
    end

endmodule

>>> filelist.f
rtl/tals_pkg.sv
rtl/tals_if.sv
rtl/tals_ctrl.sv
rtl/tals_dp.sv
rtl/three_axis_line_step_generator.sv
tb/sv/tb.sv
